/* rtl/core/spq_pkg.sv */
// shared types and constants for the sorted priority queue
// no dependencies; imported by the cell and the top level
package spq_pkg;

   localparam int OPCODE_BITS = 2;
   localparam int VALUE_BITS  = 32;
   localparam int PRIO_IN_BITS = 8;
   localparam int PRIO_MAX_BITS = 16;
   localparam int TOTAL_BITS  = 5;
   localparam int STATUS_BITS = 2;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_PUSH      = 2'd0,
      OP_POP       = 2'd1,
      OP_REMOVE_EQ = 2'd2,
      OP_REMOVE_GE = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic                         push_en;
      logic                         remove_en;
      logic signed [VALUE_BITS-1:0] value;
   } cmd_type;

endpackage

/* rtl/core/spq_if.sv */
// request and response channel interfaces of the sorted priority queue
// depends on spq_pkg for payload widths
interface spq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [spq_pkg::OPCODE_BITS-1:0]       opcode;
   logic signed [spq_pkg::VALUE_BITS-1:0] item_value;
   logic [spq_pkg::PRIO_IN_BITS-1:0]      item_priority;

   modport source (output valid, output opcode, output item_value,
                   output item_priority, input ready);
   modport sink   (input valid, input opcode, input item_value,
                   input item_priority, output ready);
endinterface

interface spq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [spq_pkg::VALUE_BITS-1:0] head_value;
   logic                                  not_empty;
   logic [spq_pkg::TOTAL_BITS-1:0]        entry_total;
   logic [spq_pkg::STATUS_BITS-1:0]       status;

   modport source (output valid, output head_value, output not_empty,
                   output entry_total, output status, input ready);
   modport sink   (input valid, input head_value, input not_empty,
                   input entry_total, input status, output ready);
endinterface

/* rtl/core/spq_cell.sv */
// one slot of the sorted chain: holds an entry and shifts with its neighbors
// depends on spq_pkg
module spq_cell #(
   parameter int PRIO_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  spq_pkg::cmd_type                      cmd,
   input  logic [PRIO_BITS-1:0]                  key,
   input  logic                                  left_valid,
   input  logic signed [spq_pkg::VALUE_BITS-1:0] left_value,
   input  logic [PRIO_BITS-1:0]                  left_prio,
   input  logic                                  left_ins,
   input  logic                                  right_valid,
   input  logic signed [spq_pkg::VALUE_BITS-1:0] right_value,
   input  logic [PRIO_BITS-1:0]                  right_prio,
   output logic                                  slot_valid,
   output logic signed [spq_pkg::VALUE_BITS-1:0] slot_value,
   output logic [PRIO_BITS-1:0]                  slot_prio,
   output logic                                  ins,
   output logic                                  ge,
   output logic                                  eq
);
   import spq_pkg::*;

   logic                         valid_ff, valid_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic [PRIO_BITS-1:0]         prio_ff, prio_in;

   // local compares against the broadcast key
   assign ins = !valid_ff || (prio_ff > key);
   assign ge  = valid_ff && (prio_ff >= key);
   assign eq  = valid_ff && (prio_ff == key);

   // insert shifts right from the insert point, removal shifts left
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      prio_in  = prio_ff;
      if (cmd.push_en) begin
         if (left_ins) begin
            valid_in = left_valid;
            value_in = left_value;
            prio_in  = left_prio;
         end else if (ins) begin
            valid_in = 1'b1;
            value_in = cmd.value;
            prio_in  = key;
         end
      end else if (cmd.remove_en) begin
         if (ge) begin
            valid_in = right_valid;
            value_in = right_value;
            prio_in  = right_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload carries no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign slot_valid = valid_ff;
   assign slot_value = value_ff;
   assign slot_prio  = prio_ff;

endmodule

/* rtl/core/sorted_priority_queue.sv */
// top level of the sorted priority queue: a chain of spq_cell slots
// depends on spq_pkg, spq_if (spq_req_if, spq_rsp_if) and spq_cell
//
//   channel  dir  word fields
//   req      in   opcode, item_value, item_priority
//   rsp      out  head_value, not_empty, entry_total, status
//
// one request per cycle: every cell compares against the key in parallel
// and the whole chain shifts at the accepting edge.
// the response is registered; it shows the queue state right after its request.
// a stalled response holds req.ready low, so the chain stays frozen while it waits.
// reset clears the slot valid bits, the fill count and the response valid.
module sorted_priority_queue #(
   parameter int DEPTH     = 16,
   parameter int PRIO_BITS = 8
) (
   input logic      clock,
   input logic      reset,
   spq_req_if.sink  req,
   spq_rsp_if.source rsp
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic                         cell_valid [DEPTH];
   logic signed [VALUE_BITS-1:0] cell_value [DEPTH];
   logic [PRIO_BITS-1:0]         cell_prio  [DEPTH];
   logic [DEPTH-1:0]             ins_vec, ge_vec, eq_vec;

   logic [PRIO_MAX_BITS-1:0] pri_wide;
   logic [PRIO_BITS-1:0]     pri_key, key;
   logic                     accept, full, found;
   cmd_type                  cmd;
   op_type                   op;

   logic [CW-1:0]          count_ff, count_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CW+TOTAL_BITS-1:0] count_pad;

   // request decode
   assign op       = op_type'(req.opcode);
   assign pri_wide = {{(PRIO_MAX_BITS-PRIO_IN_BITS){1'b0}}, req.item_priority};
   assign pri_key  = pri_wide[PRIO_BITS-1:0];
   assign key      = (op == OP_POP) ? '0 : pri_key;
   assign accept   = req.valid && req.ready;
   assign full     = (count_ff == CW'(DEPTH));

   // hit detection over the chain
   always_comb begin
      case (op)
         OP_PUSH:      found = 1'b0;
         OP_POP:       found = cell_valid[0];
         OP_REMOVE_EQ: found = |eq_vec;
         OP_REMOVE_GE: found = |ge_vec;
         default:      found = 1'b0;
      endcase
   end

   // command, count and status
   always_comb begin
      cmd.value     = req.item_value;
      cmd.push_en   = 1'b0;
      cmd.remove_en = 1'b0;
      count_in      = count_ff;
      status_in     = status_ff;
      if (accept) begin
         if (op == OP_PUSH) begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.push_en = 1'b1;
               count_in    = count_ff + 1'b1;
               status_in   = ST_DONE;
            end
         end else if (found) begin
            cmd.remove_en = 1'b1;
            count_in      = count_ff - 1'b1;
            status_in     = ST_DONE;
         end else begin
            status_in = ST_MISS;
         end
      end
   end

   // the cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                         l_valid, l_ins, r_valid;
      logic signed [VALUE_BITS-1:0] l_value, r_value;
      logic [PRIO_BITS-1:0]         l_prio, r_prio;

      if (i == 0) begin : g_head
         assign l_valid = 1'b0;
         assign l_value = '0;
         assign l_prio  = '0;
         assign l_ins   = 1'b0;
      end else begin : g_mid
         assign l_valid = cell_valid[i-1];
         assign l_value = cell_value[i-1];
         assign l_prio  = cell_prio[i-1];
         assign l_ins   = ins_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign r_valid = 1'b0;
         assign r_value = '0;
         assign r_prio  = '0;
      end else begin : g_body
         assign r_valid = cell_valid[i+1];
         assign r_value = cell_value[i+1];
         assign r_prio  = cell_prio[i+1];
      end

      spq_cell #(
         .PRIO_BITS (PRIO_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .key         (key),
         .left_valid  (l_valid),
         .left_value  (l_value),
         .left_prio   (l_prio),
         .left_ins    (l_ins),
         .right_valid (r_valid),
         .right_value (r_value),
         .right_prio  (r_prio),
         .slot_valid  (cell_valid[i]),
         .slot_value  (cell_value[i]),
         .slot_prio   (cell_prio[i]),
         .ins         (ins_vec[i]),
         .ge          (ge_vec[i]),
         .eq          (eq_vec[i])
      );
   end

   // response handshake
   assign req.ready    = !rsp_valid_ff || rsp.ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   // response word reads the frozen queue state
   assign count_pad       = {{TOTAL_BITS{1'b0}}, count_ff};
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.head_value  = cell_valid[0] ? cell_value[0] : '0;
   assign rsp.not_empty   = (count_ff != '0);
   assign rsp.entry_total = count_pad[TOTAL_BITS-1:0];
   assign rsp.status      = status_ff;

endmodule
